// File: rtl/core/sta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sta_pkg;

    typedef logic [1:0] mode_t;
    typedef logic [1:0] cmd_t;
    typedef logic [2:0] cfg_index_t;

    // Operating modes
    localparam mode_t MODE_NORMAL = 2'd0;
    localparam mode_t MODE_NIGHT  = 2'd1;
    localparam mode_t MODE_MANUAL = 2'd2;

    // Request kinds carried on s_tuser
    localparam cmd_t CMD_TICK    = 2'd0;
    localparam cmd_t CMD_CONTROL = 2'd1;
    localparam cmd_t CMD_SERIAL  = 2'd2;
    localparam cmd_t CMD_NONE    = 2'd3;

    // Serial byte codes (ASCII)
    localparam logic [7:0] BYTE_MANUAL = 8'h43; // 'C'
    localparam logic [7:0] BYTE_NORMAL = 8'h63; // 'c'
    localparam logic [7:0] BYTE_LEFT   = 8'h4C; // 'L'
    localparam logic [7:0] BYTE_RIGHT  = 8'h52; // 'R'
    localparam logic [7:0] BYTE_UP     = 8'h55; // 'U'
    localparam logic [7:0] BYTE_DOWN   = 8'h44; // 'D'

    // Configuration register indexes
    localparam cfg_index_t REG_TARGET_A    = 3'd0;
    localparam cfg_index_t REG_TARGET_B    = 3'd1;
    localparam cfg_index_t REG_GAIN_PROP   = 3'd2;
    localparam cfg_index_t REG_GAIN_INTEG  = 3'd3;
    localparam cfg_index_t REG_POS_LIMIT   = 3'd4;
    localparam cfg_index_t REG_JOG_AMOUNT  = 3'd5;
    localparam cfg_index_t REG_DARK_LIMIT  = 3'd6;
    localparam cfg_index_t REG_TICKS       = 3'd7;

    // Configuration reset values
    localparam logic [7:0]  RST_TARGET_A   = 8'd180;
    localparam logic [7:0]  RST_TARGET_B   = 8'd140;
    localparam logic [23:0] RST_GAIN_PROP  = 24'd838861;
    localparam logic [15:0] RST_GAIN_INTEG = 16'd34;
    localparam logic [15:0] RST_POS_LIMIT  = 16'd290;
    localparam logic [7:0]  RST_JOG_AMOUNT = 8'd5;
    localparam logic [11:0] RST_DARK_LIMIT = 12'd2;
    localparam logic [15:0] RST_TICKS      = 16'd1000;

    // Divide-by-ten of a 9-bit light sum: (s * 205) >> 11, exact for s <= 1028
    localparam logic [7:0] DIV10_MUL   = 8'd205;
    localparam int         DIV10_SHIFT = 11;

endpackage

`default_nettype wire

// File: rtl/core/sun_tracker_axis_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// A result shows on m_tvalid in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; the result register on the
// master side lets a new request in while the previous result is taken in the same cycle.
// The per-axis PI multiply/add/clamp path sits between state and result register.
// Reset (aresetn low, synchronous): mode normal, counters, sums, positions and
// integrals cleared, configuration registers back to their defaults.

module sun_tracker_axis_controller #(
    parameter int SAMPLES_PER_CHECK = 5,   // light samples per dark/bright check, 1..7
    parameter int FRAC_BITS         = 24   // fraction bits of positions and gains, 16..28
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // Request channel
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // tdata: light_left[7:0], light_right[15:8], sensor_axis_a[23:16],
    //        sensor_axis_b[31:24], serial_byte[39:32]
    input  wire logic [39:0]           s_tdata,
    // tuser: command[1:0]
    input  wire sta_pkg::cmd_t         s_tuser,

    // Result channel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // tdata: mode[1:0], drive_a[17:2], drive_b[33:18], light_level[39:34]
    output logic [39:0]                m_tdata,

    // Configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire sta_pkg::cfg_index_t   cfg_index,
    input  wire logic [23:0]           cfg_data
);

    import sta_pkg::*;

    // Position: 16 integer bits plus fraction; never negative after clamping
    localparam int POS_W = 16 + FRAC_BITS;
    // PI output: 34-bit proportional term plus 49-bit integral term
    localparam int Y_W   = 50;
    localparam int SUM_W = ((Y_W > POS_W + 1) ? Y_W : POS_W + 1) + 1;
    localparam int JOG_W = 8 + FRAC_BITS;
    localparam int SC_W  = (SAMPLES_PER_CHECK > 1) ? $clog2(SAMPLES_PER_CHECK) : 1;

    localparam logic signed [Y_W-1:0] ONE_Y = Y_W'(1) << FRAC_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]  target_a_reg;
    logic [7:0]  target_b_reg;
    logic [23:0] gain_prop_reg;
    logic [15:0] gain_integ_reg;
    logic [15:0] pos_limit_reg;
    logic [7:0]  jog_amount_reg;
    logic [11:0] dark_limit_reg;
    logic [15:0] ticks_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_a_reg   <= RST_TARGET_A;
            target_b_reg   <= RST_TARGET_B;
            gain_prop_reg  <= RST_GAIN_PROP;
            gain_integ_reg <= RST_GAIN_INTEG;
            pos_limit_reg  <= RST_POS_LIMIT;
            jog_amount_reg <= RST_JOG_AMOUNT;
            dark_limit_reg <= RST_DARK_LIMIT;
            ticks_reg      <= RST_TICKS;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_TARGET_A:   target_a_reg   <= cfg_data[7:0];
                REG_TARGET_B:   target_b_reg   <= cfg_data[7:0];
                REG_GAIN_PROP:  gain_prop_reg  <= cfg_data;
                REG_GAIN_INTEG: gain_integ_reg <= cfg_data[15:0];
                REG_POS_LIMIT:  pos_limit_reg  <= cfg_data[15:0];
                REG_JOG_AMOUNT: jog_amount_reg <= cfg_data[7:0];
                REG_DARK_LIMIT: dark_limit_reg <= cfg_data[11:0];
                REG_TICKS:      ticks_reg      <= cfg_data[15:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request fields
    // ------------------------------------------------------------------
    logic       accept;
    cmd_t       cmd;
    logic [7:0] light_left;
    logic [7:0] light_right;
    logic [7:0] sensor [2];
    logic [7:0] serial_byte;

    assign accept      = s_tvalid && s_tready;
    assign cmd         = s_tuser;
    assign light_left  = s_tdata[7:0];
    assign light_right = s_tdata[15:8];
    assign sensor[0]   = s_tdata[23:16];
    assign sensor[1]   = s_tdata[31:24];
    assign serial_byte = s_tdata[39:32];

    // ------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------
    mode_t                    mode_reg,        mode_next;
    logic [7:0]               last_byte_reg,   last_byte_next;
    logic [15:0]              tick_cnt_reg,    tick_cnt_next;
    logic [SC_W-1:0]          sample_cnt_reg,  sample_cnt_next;
    logic [11:0]              light_sum_reg,   light_sum_next;
    logic [POS_W-1:0]         pos_reg   [2];
    logic [POS_W-1:0]         pos_next  [2];
    logic signed [31:0]       integ_reg [2];
    logic signed [31:0]       integ_next[2];

    function automatic logic signed [SUM_W-1:0] ext_pos(input logic [POS_W-1:0] p);
        return $signed({{(SUM_W - POS_W){1'b0}}, p});
    endfunction

    function automatic logic [POS_W-1:0] clamp_pos(input logic signed [SUM_W-1:0] p,
                                                    input logic [POS_W-1:0]        top);
        logic signed [SUM_W-1:0] top_s;
        top_s = ext_pos(top);
        if (p < 0) begin
            return '0;
        end else if (p > top_s) begin
            return top;
        end else begin
            return p[POS_W-1:0];
        end
    endfunction

    // Full-scale position (limit with zero fraction), also the night parking spot
    logic [POS_W-1:0]        pos_top;
    logic signed [SUM_W-1:0] jog_step;

    assign pos_top  = {pos_limit_reg, {FRAC_BITS{1'b0}}};
    assign jog_step = $signed({{(SUM_W - JOG_W){1'b0}}, jog_amount_reg, {FRAC_BITS{1'b0}}});

    // PI law for both axes, evaluated side by side
    logic [7:0]              target  [2];
    logic signed [8:0]       err     [2];
    logic signed [32:0]      acc_wide[2];
    logic signed [31:0]      acc     [2];
    logic signed [33:0]      prod_p  [2];
    logic signed [48:0]      prod_i  [2];
    logic signed [Y_W-1:0]   y_raw   [2];
    logic signed [Y_W-1:0]   y_dz    [2];
    logic [POS_W-1:0]        pi_pos  [2];

    assign target[0] = target_a_reg;
    assign target[1] = target_b_reg;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            err[i]      = $signed({1'b0, target[i]}) - $signed({1'b0, sensor[i]});
            acc_wide[i] = $signed({integ_reg[i][31], integ_reg[i]})
                          + $signed({{24{err[i][8]}}, err[i]});
            // saturate the integral to 32 bits
            if (acc_wide[i][32] != acc_wide[i][31]) begin
                acc[i] = acc_wide[i][32] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
            end else begin
                acc[i] = acc_wide[i][31:0];
            end
            prod_p[i] = $signed({1'b0, gain_prop_reg}) * err[i];
            prod_i[i] = $signed({1'b0, gain_integ_reg}) * acc[i];
            y_raw[i]  = $signed({{(Y_W - 34){prod_p[i][33]}}, prod_p[i]})
                        + $signed({prod_i[i][48], prod_i[i]});
            // dead zone: magnitude under one position unit moves nothing
            if (y_raw[i] > -ONE_Y && y_raw[i] < ONE_Y) begin
                y_dz[i] = '0;
            end else begin
                y_dz[i] = y_raw[i];
            end
            pi_pos[i] = clamp_pos(ext_pos(pos_reg[i])
                                  + $signed({{(SUM_W - Y_W){y_dz[i][Y_W-1]}}, y_dz[i]}),
                                  pos_top);
        end
    end

    // Tick path helpers
    logic [16:0]     tick_inc;
    logic [SC_W:0]   sample_inc;
    logic [11:0]     light_sum_add;

    assign tick_inc      = {1'b0, tick_cnt_reg} + 17'd1;
    assign sample_inc    = {1'b0, sample_cnt_reg} + (SC_W + 1)'(1);
    assign light_sum_add = light_sum_reg + {4'd0, light_left} + {4'd0, light_right};

    always_comb begin
        mode_next       = mode_reg;
        last_byte_next  = last_byte_reg;
        tick_cnt_next   = tick_cnt_reg;
        sample_cnt_next = sample_cnt_reg;
        light_sum_next  = light_sum_reg;
        pos_next[0]     = pos_reg[0];
        pos_next[1]     = pos_reg[1];
        integ_next[0]   = integ_reg[0];
        integ_next[1]   = integ_reg[1];

        unique case (cmd)
            CMD_TICK: begin
                if (tick_inc >= {1'b0, ticks_reg}) begin
                    tick_cnt_next = '0;
                    if (sample_inc >= (SC_W + 1)'(SAMPLES_PER_CHECK)) begin
                        sample_cnt_next = '0;
                        light_sum_next  = '0;
                        // manual mode keeps its mode; the sum is dropped anyway
                        if (mode_reg != MODE_MANUAL) begin
                            if (light_sum_add <= dark_limit_reg) begin
                                mode_next   = MODE_NIGHT;
                                pos_next[0] = pos_top;
                                pos_next[1] = pos_top;
                            end else begin
                                mode_next = MODE_NORMAL;
                            end
                        end
                    end else begin
                        sample_cnt_next = sample_inc[SC_W-1:0];
                        light_sum_next  = light_sum_add;
                    end
                end else begin
                    tick_cnt_next = tick_inc[15:0];
                end
            end
            CMD_CONTROL: begin
                if (mode_reg == MODE_NORMAL) begin
                    pos_next[0]   = pi_pos[0];
                    pos_next[1]   = pi_pos[1];
                    integ_next[0] = acc[0];
                    integ_next[1] = acc[1];
                end else if (mode_reg == MODE_MANUAL) begin
                    unique case (last_byte_reg)
                        BYTE_LEFT:  pos_next[0] = clamp_pos(ext_pos(pos_reg[0]) + jog_step,
                                                            pos_top);
                        BYTE_RIGHT: pos_next[0] = clamp_pos(ext_pos(pos_reg[0]) - jog_step,
                                                            pos_top);
                        BYTE_UP:    pos_next[1] = clamp_pos(ext_pos(pos_reg[1]) + jog_step,
                                                            pos_top);
                        BYTE_DOWN:  pos_next[1] = clamp_pos(ext_pos(pos_reg[1]) - jog_step,
                                                            pos_top);
                        default: ;
                    endcase
                end
            end
            CMD_SERIAL: begin
                last_byte_next = serial_byte;
                if (serial_byte == BYTE_MANUAL) begin
                    mode_next = MODE_MANUAL;
                end else if (serial_byte == BYTE_NORMAL) begin
                    mode_next = MODE_NORMAL;
                end
            end
            CMD_NONE: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_NORMAL;
            last_byte_reg  <= '0;
            tick_cnt_reg   <= '0;
            sample_cnt_reg <= '0;
            light_sum_reg  <= '0;
            pos_reg[0]     <= '0;
            pos_reg[1]     <= '0;
            integ_reg[0]   <= '0;
            integ_reg[1]   <= '0;
        end else if (accept) begin
            mode_reg       <= mode_next;
            last_byte_reg  <= last_byte_next;
            tick_cnt_reg   <= tick_cnt_next;
            sample_cnt_reg <= sample_cnt_next;
            light_sum_reg  <= light_sum_next;
            pos_reg[0]     <= pos_next[0];
            pos_reg[1]     <= pos_next[1];
            integ_reg[0]   <= integ_next[0];
            integ_reg[1]   <= integ_next[1];
        end
    end

    // ------------------------------------------------------------------
    // Display light level: (left + right) / 10 + 1 via reciprocal multiply
    // ------------------------------------------------------------------
    logic [8:0]  light_pair;
    logic [16:0] light_prod;
    logic [5:0]  light_level;

    assign light_pair  = {1'b0, light_left} + {1'b0, light_right};
    assign light_prod  = {8'd0, light_pair} * {9'd0, DIV10_MUL};
    assign light_level = light_prod[DIV10_SHIFT +: 6] + 6'd1;

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {light_level,
                            pos_next[1][FRAC_BITS +: 16],
                            pos_next[0][FRAC_BITS +: 16],
                            mode_next};
        end
    end

`ifndef NO_ASSERTIONS
    // an accepted request always leaves a result waiting
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted request produced no result");

    // night mode: a control step must not move either axis
    a_night_still: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && cmd == CMD_CONTROL && mode_reg == MODE_NIGHT)
        |=> ($stable(pos_reg[0]) && $stable(pos_reg[1])))
        else $error("axis moved on control step in night mode");

    // the light check never pulls the block out of manual mode
    a_manual_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && cmd == CMD_TICK && mode_reg == MODE_MANUAL)
        |=> mode_reg == MODE_MANUAL)
        else $error("tick changed manual mode");

    // sample counter wraps before reaching the check count
    a_sample_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, sample_cnt_reg} < (SC_W + 1)'(SAMPLES_PER_CHECK)))
        else $error("sample counter out of range");
`endif

endmodule

`default_nettype wire
